// ===== sv/vsd_pkg.sv =====
// Package for the base-128 varint stream decoder.
// Holds field widths, byte bounds and the result type. No dependencies.
`default_nettype none

package vsd_pkg;

    // Field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned ValueW  = 64;
    localparam int unsigned CountW  = 4;
    localparam int unsigned ShiftW  = 6;
    localparam int unsigned PayW    = 7;
    localparam int unsigned HalfW   = 32;
    localparam int unsigned CfgIdxW = 4;
    localparam int unsigned CfgDatW = 4;

    // Byte bounds per mode
    localparam logic [CountW-1:0] ShortBound = 4'd5;
    localparam logic [CountW-1:0] LongBound  = 4'd10;
    localparam logic [CountW-1:0] LimitReset = 4'd10;

    // Continuation flag position in a stream byte
    localparam int unsigned ContBit = 7;

    // Configuration register indices
    localparam logic [CfgIdxW-1:0] RegLongMode    = 4'd0;
    localparam logic [CfgIdxW-1:0] RegLengthLimit = 4'd1;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [CountW-1:0] byte_count;
        logic              status;
    } result_t;

    // Bit position of a payload group: 7 times the byte index (index below 10)
    function automatic logic [ShiftW-1:0] group_shift(input logic [CountW-1:0] idx);
        logic [ShiftW-1:0] s;
        unique case (idx)
            4'd0:    s = 6'd0;
            4'd1:    s = 6'd7;
            4'd2:    s = 6'd14;
            4'd3:    s = 6'd21;
            4'd4:    s = 6'd28;
            4'd5:    s = 6'd35;
            4'd6:    s = 6'd42;
            4'd7:    s = 6'd49;
            4'd8:    s = 6'd56;
            4'd9:    s = 6'd63;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/varint_stream_decoder.sv =====
// Base-128 varint stream decoder, top level.
// Depends on vsd_pkg for widths, bounds and the result type.
`default_nettype none

// Takes one stream byte per cycle while in_stall is low and emits one
// result beat when a value ends (a byte with bit 7 clear) or when a byte
// arrives at an index at or beyond the byte bound (status 1, value 0,
// byte count 0, value restarted). The bound is the smaller of
// length_limit and the mode bound: 5 bytes in 32-bit mode, whose result
// is the low 32 bits sign-extended, or 10 bytes in 64-bit mode. The
// shift-or into the accumulator, the count update and the result
// formatting all sit between the byte port and the accumulator and result
// registers. A two-entry output stage (result register plus skid
// register) lets bytes keep flowing while a result waits; in_stall rises
// only when both entries are full. Configuration writes are always ready
// and take effect on the next byte.

module varint_stream_decoder
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [vsd_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [vsd_pkg::CfgDatW-1:0]    cfg_data,

    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [vsd_pkg::ByteW-1:0]      data_byte,

    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic signed [vsd_pkg::ValueW-1:0] value,
    output      logic [vsd_pkg::CountW-1:0]     byte_count,
    output      logic                           status
);

    // Configuration registers
    logic                         long_mode_reg;
    logic [vsd_pkg::CountW-1:0]   length_limit_reg;

    // Decode state
    logic [vsd_pkg::ValueW-1:0]   acc_reg, acc_next;
    logic [vsd_pkg::CountW-1:0]   idx_reg, idx_next;

    // Output stage
    vsd_pkg::result_t             out_reg, skid_reg;
    logic                         out_valid_reg, skid_valid_reg;

    // Per-beat combinational result
    vsd_pkg::result_t             res;
    logic                         res_valid;

    logic                         in_take;
    logic [vsd_pkg::CountW-1:0]   bound;
    logic [vsd_pkg::CountW-1:0]   mode_bound;
    logic                         over_bound;
    logic [vsd_pkg::ValueW-1:0]   merged;
    logic [vsd_pkg::CountW-1:0]   idx_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;

    // Configuration writes; unknown indices ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg    <= 1'b0;
            length_limit_reg <= vsd_pkg::LimitReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == vsd_pkg::RegLongMode)
                long_mode_reg <= cfg_data[0];
            else if (cfg_index == vsd_pkg::RegLengthLimit)
                length_limit_reg <= cfg_data;
        end
    end

    // Byte bound, payload merge and result formatting
    always_comb
    begin
        mode_bound = long_mode_reg ? vsd_pkg::LongBound : vsd_pkg::ShortBound;
        bound      = (length_limit_reg < mode_bound) ? length_limit_reg : mode_bound;
        over_bound = (idx_reg >= bound);
        merged     = acc_reg | ({{(vsd_pkg::ValueW-vsd_pkg::PayW){1'b0}},
                                 data_byte[vsd_pkg::PayW-1:0]}
                                << vsd_pkg::group_shift(idx_reg));
        idx_inc    = idx_reg + 4'd1;

        acc_next   = acc_reg;
        idx_next   = idx_reg;
        res_valid  = 1'b0;
        res.value      = '0;
        res.byte_count = '0;
        res.status     = vsd_pkg::STATUS_OK;

        if (in_take)
        begin
            if (over_bound)
            begin
                // dropped byte: report invalid and restart
                acc_next   = '0;
                idx_next   = '0;
                res_valid  = 1'b1;
                res.status = vsd_pkg::STATUS_INVALID;
            end
            else if (data_byte[vsd_pkg::ContBit])
            begin
                acc_next = merged;
                idx_next = idx_inc;
            end
            else
            begin
                // final byte of the value
                acc_next       = '0;
                idx_next       = '0;
                res_valid      = 1'b1;
                res.byte_count = idx_inc;
                if (long_mode_reg)
                    res.value = merged;
                else
                    res.value = {{(vsd_pkg::ValueW-vsd_pkg::HalfW)
                                  {merged[vsd_pkg::HalfW-1]}},
                                 merged[vsd_pkg::HalfW-1:0]};
            end
        end
    end

    // Decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            idx_reg <= idx_next;
        end
    end

    // Output stage valid flags: skid fills only while the result beat is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_stall)
        begin
            if (res_valid)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_stall)
        begin
            if (res_valid)
                skid_reg <= res;
        end
        else if (skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = out_reg.value;
    assign byte_count = out_reg.byte_count;
    assign status     = out_reg.status;

endmodule

`default_nettype wire
